@@ design/mbgac_pkg.sv @@
// Package for the mic block gate/AGC compressor: shared constants and types.
// No dependencies.
`default_nettype none
package mbgac_pkg;
  localparam logic [15:0] GAIN_ONE  = 16'd16384;
  localparam logic [15:0] GAIN_MIN  = 16'd13107;
  localparam logic [15:0] GAIN_MAX  = 16'd39321;
  localparam logic [14:0] KNEE_Q15  = 15'd18022;
  localparam logic [14:0] SLOPE_Q15 = 15'd11468;
  localparam logic [14:0] SCALE_Q15 = 15'd30146;
  localparam logic [1:0] CFG_FLOOR  = 2'd0;
  localparam logic [1:0] CFG_CEIL   = 2'd1;
  localparam logic [1:0] CFG_TARGET = 2'd2;

  // Request to the shared divider and its answer.
  typedef struct packed {
    logic        go;
    logic        neg;
    logic [29:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [29:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ design/mbgac_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module mbgac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire                                      clk,
  input  wire                                      we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                          wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/mbgac_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on mbgac_pkg.
`default_nettype none
module mbgac_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mbgac_pkg::div_req_t req,
  output mbgac_pkg::div_rsp_t rsp
);
  logic [29:0] quo_r, quo_nxt;
  logic [29:0] rem_r, rem_nxt;
  logic [16:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [30:0] trial;

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    trial = {rem_r, quo_r[29]};
    if (req.go) begin
      quo_nxt = req.num; rem_nxt = '0; den_nxt = req.den;
      cnt_nxt = 5'd29; busy_nxt = 1'b1; neg_nxt = req.neg;
    end else if (busy_r) begin
      quo_nxt = {quo_r[28:0], 1'b0};
      if (trial >= {14'd0, den_r}) begin
        rem_nxt = 30'(trial - {14'd0, den_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[29:0];
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; neg_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? 30'(-quo_r) : quo_r;
endmodule
`default_nettype wire

@@ design/mic_block_gate_agc_compressor.sv @@
// Top level of the mic block gate/AGC compressor: sequencer and datapath.
// Depends on mbgac_pkg, mbgac_ram and mbgac_div.
//
//  channel | ports                                  | handshake
//  input   | start, busy, in_sample_in, in_block_end | start && !busy
//  result  | out_valid, out_sample_out, out_run_end, | strobe, one cycle
//          | out_level_mean_abs, out_level_peak      |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// A sample that does not end the block is taken while busy stays low. After the closing
// request busy stays high while the block runs through its steps in order: the DC and
// level means on the 30-step divider, limiting the gate, pass 2 (read, then write back),
// the gain divide (gain set to one when the pass-2 peak is zero), pass 3 through its
// three-stage pipeline, the final level mean and the final result. Reset is synchronous
// and clears all control state; the memory needs no clearing since only written entries
// are read. The receiver cannot stall: pass-3 results are strobed one per cycle, the last
// one after the level mean.
`default_nettype none
module mic_block_gate_agc_compressor #(
  parameter int BLOCK_DEPTH = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire signed [15:0] in_sample_in,
  input  wire               in_block_end,
  output logic              out_valid,
  output logic signed [15:0] out_sample_out,
  output logic              out_run_end,
  output logic [15:0]       out_level_mean_abs,
  output logic [15:0]       out_level_peak,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [1:0]         cfg_index,
  input  wire [14:0]        cfg_data
);
  localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int CW = $clog2(BLOCK_DEPTH + 1);

  // 17 * ceil(2^24 / 20): a*85/100 equals (17a)/20, exact for any level below the gate.
  localparam logic [23:0] GATE_SCALE_RECIP = 24'd14260637;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DCDIV = 4'd1;
  localparam logic [3:0] S_AVDIV = 4'd2;
  localparam logic [3:0] S_GATE  = 4'd3;
  localparam logic [3:0] S_P2    = 4'd4;
  localparam logic [3:0] S_GDIV  = 4'd5;
  localparam logic [3:0] S_P3    = 4'd6;
  localparam logic [3:0] S_MDIV  = 4'd7;
  localparam logic [3:0] S_LAST  = 4'd8;

  logic [3:0]  st_r, st_nxt;
  logic [14:0] floor_r, ceil_r, target_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic signed [22:0] stot_r, stot_nxt;
  logic [22:0] mtot_r, mtot_nxt;
  logic [16:0] pk_r, pk_nxt;          // pass-2 peak
  logic [28:0] tot3_r, tot3_nxt;
  logic signed [16:0] dc_r, dc_nxt;
  logic [15:0] gate_r, gate_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [CW-1:0] rd_r, rd_nxt;        // read pointer
  logic [CW-1:0] wb_r, wb_nxt;        // count of entries whose read data has arrived
  logic        rv_r, rv_nxt;          // read data valid next cycle
  logic [AW-1:0] ra_r, ra_nxt;        // address of data in flight
  logic        launched_r, launched_nxt;

  // Pass 3 pipeline registers
  logic        p3v_r, p3last_r, p3neg_r;
  logic [31:0] p3m_r;
  logic        p3bv_r, p3blast_r, p3bneg_r;
  logic [16:0] p3b_r;
  logic        p3cv_r, p3clast_r, p3cneg_r;
  logic [31:0] p3c_r;

  logic        ov_r, olast_r;
  logic signed [15:0] osamp_r;
  logic [15:0] omean_r;
  logic [15:0] peak3_hold_r;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  mbgac_pkg::div_req_t dreq;
  mbgac_pkg::div_rsp_t drsp;

  mbgac_ram #(.WIDTH(16), .DEPTH(BLOCK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  mbgac_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign busy      = (st_r != S_LOAD);
  assign cfg_ready = (st_r == S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= 15'd40; ceil_r <= 15'd280; target_r <= 15'd12000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbgac_pkg::CFG_FLOOR:  floor_r  <= cfg_data;
        mbgac_pkg::CFG_CEIL:   ceil_r   <= cfg_data;
        mbgac_pkg::CFG_TARGET: target_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pass 2 on the word read from memory
  logic signed [17:0] v2, v2s;
  logic [17:0] a2, a2s, sc2;
  logic [41:0] sc2p;
  logic signed [17:0] res2;
  logic [15:0] sat2;
  logic [17:0] fade;
  always_comb begin
    fade = {3'd0, gate_r[15:1]};
    v2   = 18'(signed'(rdata)) - 18'(dc_r);
    a2   = v2[17] ? 18'(-v2) : v2;
    sc2p = 42'(a2) * 42'(GATE_SCALE_RECIP);
    sc2  = sc2p[41:24];
    v2s  = v2;
    if (a2 < fade) begin
      v2s = 18'((19'(v2) * 19'sd3) / 19'sd4);
    end else if (a2 < {2'd0, gate_r}) begin
      v2s = v2[17] ? 18'(-sc2) : 18'(sc2);
    end
    res2 = v2s;
    a2s  = res2[17] ? 18'(-res2) : res2;
    if (res2 > 18'sd32767) sat2 = 16'h7fff;
    else if (res2 < -18'sd32768) sat2 = 16'h8000;
    else sat2 = res2[15:0];
  end

  // Pass 3 stage inputs
  logic [15:0] mag3;
  logic [16:0] kn;
  logic [31:0] sl;
  assign mag3 = rdata[15] ? 16'(-rdata) : rdata;
  always_comb begin
    kn = p3m_r[30:14] > 17'(mbgac_pkg::KNEE_Q15) ? 17'(mbgac_pkg::KNEE_Q15) : p3m_r[30:14];
    sl = 32'(p3m_r[30:14] - 17'(mbgac_pkg::KNEE_Q15)) * 32'(mbgac_pkg::SLOPE_Q15);
  end
  logic [16:0] kmag;
  logic [31:0] vsc;
  logic [16:0] vfin;
  logic [32:0] vmul;
  assign kmag = (p3m_r[30:14] > 17'(mbgac_pkg::KNEE_Q15))
              ? 17'(kn + sl[31:15]) : p3m_r[30:14];
  assign vsc  = 32'(p3b_r) * 32'(mbgac_pkg::SCALE_Q15);
  assign vmul = 33'(p3c_r[31:15]) * 33'd32767;
  assign vfin = vmul[31:15];

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; stot_nxt = stot_r; mtot_nxt = mtot_r;
    pk_nxt = pk_r; tot3_nxt = tot3_r; dc_nxt = dc_r; gate_nxt = gate_r;
    gain_nxt = gain_r; rd_nxt = rd_r; wb_nxt = wb_r; rv_nxt = 1'b0; ra_nxt = ra_r;
    launched_nxt = launched_r;
    we = 1'b0; waddr = ra_r; wdata = sat2; raddr = rd_r[AW-1:0];
    dreq = '0;
    case (st_r)
      S_LOAD: begin
        waddr = fill_r[AW-1:0];
        wdata = in_sample_in;
        if (start) begin
          we = 1'b1;
          fill_nxt = fill_r + CW'(1);
          stot_nxt = stot_r + 23'(in_sample_in);
          mtot_nxt = mtot_r + 23'(in_sample_in[15] ? 17'(-17'(in_sample_in))
                                                   : 17'(in_sample_in));
          if (in_block_end || (fill_r + CW'(1) == CW'(BLOCK_DEPTH))) begin
            st_nxt = S_DCDIV; launched_nxt = 1'b0;
          end
        end
      end
      S_DCDIV: begin
        if (!launched_r) begin
          dreq.go = 1'b1; dreq.neg = stot_r[22];
          dreq.num = 30'(stot_r[22] ? 23'(-stot_r) : stot_r);
          dreq.den = 17'(fill_r); launched_nxt = 1'b1;
        end else if (drsp.done) begin
          dc_nxt = 17'(drsp.quo); st_nxt = S_AVDIV; launched_nxt = 1'b0;
        end
      end
      S_AVDIV: begin
        if (!launched_r) begin
          dreq.go = 1'b1; dreq.num = 30'(mtot_r); dreq.den = 17'(fill_r);
          launched_nxt = 1'b1;
        end else if (drsp.done) begin
          gate_nxt = drsp.quo[18:3];
          st_nxt = S_GATE;
        end
      end
      S_GATE: begin
        if (gate_r < {1'b0, floor_r}) gate_nxt = {1'b0, floor_r};
        else if (gate_r > {1'b0, ceil_r}) gate_nxt = {1'b0, ceil_r};
        pk_nxt = '0; rd_nxt = '0; wb_nxt = '0;
        st_nxt = S_P2;
      end
      S_P2: begin
        // read one entry a cycle, write back its pass-2 value the next cycle
        if (rd_r < fill_r) begin
          rv_nxt = 1'b1; ra_nxt = rd_r[AW-1:0]; rd_nxt = rd_r + CW'(1);
        end
        if (rv_r) begin
          we = 1'b1;
          if (a2s[16:0] > pk_r) pk_nxt = a2s[16:0];
          wb_nxt = wb_r + CW'(1);
          if (wb_r + CW'(1) == fill_r) begin
            st_nxt = S_GDIV; launched_nxt = 1'b0;
          end
        end
      end
      S_GDIV: begin
        if (pk_r == '0) begin
          gain_nxt = mbgac_pkg::GAIN_ONE;
          st_nxt = S_P3; rd_nxt = '0; wb_nxt = '0; tot3_nxt = '0;
        end else if (!launched_r) begin
          dreq.go = 1'b1; dreq.num = {1'b0, target_r, 14'd0}; dreq.den = pk_r;
          launched_nxt = 1'b1;
        end else if (drsp.done) begin
          if (drsp.quo < 30'(mbgac_pkg::GAIN_MIN)) gain_nxt = mbgac_pkg::GAIN_MIN;
          else if (drsp.quo > 30'(mbgac_pkg::GAIN_MAX)) gain_nxt = mbgac_pkg::GAIN_MAX;
          else gain_nxt = drsp.quo[15:0];
          st_nxt = S_P3; rd_nxt = '0; wb_nxt = '0; tot3_nxt = '0;
        end
      end
      S_P3: begin
        if (rd_r < fill_r) begin
          rv_nxt = 1'b1; rd_nxt = rd_r + CW'(1);
        end
        if (p3cv_r) begin
          tot3_nxt = tot3_r + 29'(vfin);
          if (p3clast_r) begin
            st_nxt = S_MDIV; launched_nxt = 1'b0;
          end
        end
      end
      S_MDIV: begin
        if (!launched_r) begin
          dreq.go = 1'b1; dreq.num = 30'(tot3_r); dreq.den = 17'(fill_r);
          launched_nxt = 1'b1;
        end else if (drsp.done) begin
          st_nxt = S_LAST;
        end
      end
      S_LAST: begin
        st_nxt = S_LOAD; fill_nxt = '0; stot_nxt = '0; mtot_nxt = '0;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  // Pass-3 peak of |v| before saturation
  logic [16:0] pk3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; fill_r <= '0; stot_r <= '0; mtot_r <= '0; rv_r <= 1'b0;
      launched_r <= 1'b0; p3v_r <= 1'b0; p3bv_r <= 1'b0; p3cv_r <= 1'b0;
      ov_r <= 1'b0; olast_r <= 1'b0; rd_r <= '0; wb_r <= '0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; stot_r <= stot_nxt; mtot_r <= mtot_nxt;
      rv_r <= rv_nxt; launched_r <= launched_nxt; rd_r <= rd_nxt;
      wb_r <= (st_r == S_P3 && rv_r) ? wb_r + CW'(1) : wb_nxt;
      p3v_r  <= (st_r == S_P3) && rv_r;
      p3bv_r <= p3v_r;
      p3cv_r <= p3bv_r;
      ov_r    <= p3cv_r;
      olast_r <= p3cv_r && p3clast_r;
    end
    pk_r <= pk_nxt; tot3_r <= tot3_nxt; dc_r <= dc_nxt; gate_r <= gate_nxt;
    gain_r <= gain_nxt; ra_r <= ra_nxt;
    // stage 1: magnitude times gain
    p3m_r <= 32'(mag3) * 32'(gain_r);
    p3neg_r <= rdata[15];
    p3last_r <= (wb_r == fill_r - CW'(1));
    // stage 2: soft knee on the gained magnitude
    p3b_r <= kmag; p3bneg_r <= p3neg_r; p3blast_r <= p3last_r;
    // stage 3: knee result times scale
    p3c_r <= vsc; p3clast_r <= p3blast_r; p3cneg_r <= p3bneg_r;
    if (st_r == S_GDIV) pk3_r <= '0;
    else if (p3cv_r && vfin > pk3_r) pk3_r <= vfin;
    // output register, held so that the last sample waits for the level mean
    if (p3cv_r) begin
      osamp_r <= p3cneg_r ? 16'(-(vfin > 17'd32768 ? 17'd32768 : vfin))
                          : (vfin > 17'd32767 ? 16'h7fff : vfin[15:0]);
    end
    peak3_hold_r <= (p3cv_r && vfin > pk3_r) ? vfin[15:0] : pk3_r[15:0];
    if (drsp.done && st_r == S_MDIV) omean_r <= drsp.quo[15:0];
  end

  // The last result waits in the output register until the mean is known.
  assign out_valid          = (ov_r && !olast_r) || (st_r == S_LAST);
  assign out_sample_out     = osamp_r;
  assign out_run_end        = (st_r == S_LAST);
  assign out_level_mean_abs = (st_r == S_LAST) ? omean_r : 16'd0;
  assign out_level_peak     = (st_r == S_LAST) ? peak3_hold_r : 16'd0;
endmodule
`default_nettype wire

@@ design/mbgac_checker.sv @@
// Port-level checker for the mic block gate/AGC compressor, with its bind.
// Depends on mic_block_gate_agc_compressor.
`default_nettype none
module mbgac_checker (
  input wire clk, input wire rst_n, input wire start, input wire busy,
  input wire out_valid, input wire out_run_end,
  input wire [15:0] out_level_mean_abs, input wire [15:0] out_level_peak,
  input wire cfg_ready
);
  a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_run_end |-> out_valid) else $error("run_end without strobe");
  a_levels_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_end) |-> (out_level_peak == 16'd0 && out_level_mean_abs == 16'd0))
    else $error("levels on non-final result");
  a_idle_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !busy) else $error("cfg ready while busy");
  a_end_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_run_end |=> !busy) else $error("still busy after block end");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !out_valid) else $error("result while loading");
endmodule

bind mic_block_gate_agc_compressor mbgac_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_run_end(out_run_end), .out_level_mean_abs(out_level_mean_abs),
  .out_level_peak(out_level_peak), .cfg_ready(cfg_ready)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for the mic block gate/AGC compressor: stimulus, predictor, checks.
// Depends on mbgac_pkg and mic_block_gate_agc_compressor from the design folder.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and the block's ports. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_sample_in = '0;
  logic in_block_end = 1'b0;
  logic out_valid;
  logic signed [15:0] out_sample_out;
  logic out_run_end;
  logic [15:0] out_level_mean_abs;
  logic [15:0] out_level_peak;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mic_block_gate_agc_compressor uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_in(in_sample_in), .in_block_end(in_block_end),
    .out_valid(out_valid), .out_sample_out(out_sample_out),
    .out_run_end(out_run_end), .out_level_mean_abs(out_level_mean_abs),
    .out_level_peak(out_level_peak), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One processed sample as the result port presents it.
  typedef struct {
    logic signed [15:0] smp;
    logic run_end;
    logic [15:0] mean_abs;
    logic [15:0] peak;
  } cleaned_t;

  // One row of the directed table. Where typed is set, the expected result
  // is given in the row itself rather than taken from the predictor.
  typedef struct {
    logic signed [15:0] smp;
    logic last;
    logic typed;
    logic signed [15:0] e_smp;
    logic e_end;
    logic [15:0] e_mean;
    logic [15:0] e_peak;
  } row_t;

  localparam int DEPTH = 64;
  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 6000;

  // Predictor copy of the block's registers and loading state.
  int gate_floor_q = 40;
  int gate_ceiling_q = 280;
  int peak_target_q = 12000;
  int block_store[DEPTH];
  int fill_n = 0;
  longint sum_signed = 0;
  longint sum_mag = 0;

  cleaned_t cleaned_q[$];
  int errors = 0;
  int quiet_cycles = 0;

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Gain, soft-knee compression and output scale on one gated sample.
  // The magnitude is shaped and the sign put back afterwards.
  function automatic int compress_sample(int s, longint gain);
    longint m;
    m = mag(s);
    m = (m * gain) >>> 14;
    if (m > mbgac_pkg::KNEE_Q15)
      m = mbgac_pkg::KNEE_Q15 + (((m - mbgac_pkg::KNEE_Q15) * mbgac_pkg::SLOPE_Q15) >>> 15);
    m = (m * mbgac_pkg::SCALE_Q15) >>> 15;
    m = (m * 32767) / 32768;
    return (s < 0) ? -int'(m) : int'(m);
  endfunction

  // Runs the three passes over the loaded block and queues its results.
  // When typed_ok is set the typed row result replaces the prediction of the last result.
  task automatic clean_block(input logic typed_ok, input cleaned_t typed_res);
    int dc, avg, gate, fade, v, a, peak2, peak3;
    longint gain, total3;
    cleaned_t r;
    dc = int'(sum_signed / fill_n);
    avg = int'(sum_mag / fill_n);
    gate = avg / 8;
    if (gate < gate_floor_q) gate = gate_floor_q;
    else if (gate > gate_ceiling_q) gate = gate_ceiling_q;
    fade = gate / 2;
    peak2 = 0;
    for (int i = 0; i < fill_n; i++) begin
      v = block_store[i] - dc;
      a = mag(v);
      if (a < fade) v = (v * 3) / 4;
      else if (a < gate) v = (v < 0) ? -((a * 85) / 100) : (a * 85) / 100;
      block_store[i] = sat16(v);
      // The pass-2 peak uses the value before saturation.
      if (mag(v) > peak2) peak2 = mag(v);
    end
    gain = mbgac_pkg::GAIN_ONE;
    if (peak2 > 0) gain = (longint'(peak_target_q) << 14) / peak2;
    if (gain < mbgac_pkg::GAIN_MIN) gain = mbgac_pkg::GAIN_MIN;
    if (gain > mbgac_pkg::GAIN_MAX) gain = mbgac_pkg::GAIN_MAX;
    total3 = 0;
    peak3 = 0;
    for (int i = 0; i < fill_n; i++) begin
      v = compress_sample(block_store[i], gain);
      a = mag(v);
      total3 += a;
      if (a > peak3) peak3 = a;
      r.smp = 16'(sat16(v));
      r.run_end = (i == fill_n - 1);
      r.mean_abs = r.run_end ? 16'(total3 / fill_n) : 16'd0;
      r.peak = r.run_end ? 16'(peak3) : 16'd0;
      if (r.run_end && typed_ok) r = typed_res;
      cleaned_q.push_back(r);
    end
    fill_n = 0;
    sum_signed = 0;
    sum_mag = 0;
  endtask

  // Loads one accepted sample; a marked end or a full store closes the block.
  task automatic load_sample(input int s, input logic last, input logic typed_ok,
                             input cleaned_t typed_res);
    block_store[fill_n] = s;
    fill_n++;
    sum_signed += s;
    sum_mag += mag(s);
    if (last || fill_n >= DEPTH) clean_block(typed_ok, typed_res);
  endtask

  // Sends one sample request after a random gap. With no gap, start stays
  // high and only the payload changes, so start never gets two updates.
  task automatic send_sample(input logic signed [15:0] s, input logic last,
                             input logic typed_ok, input cleaned_t typed_res);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_sample_in <= s;
    in_block_end <= last;
    do @(posedge clk); while (busy);
    load_sample(int'(s), last, typed_ok, typed_res);
  endtask

  // Waits until every queued result has come, then idles for a while
  // before anything else is done.
  task automatic drain_results();
    start <= 1'b0;
    while (cleaned_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid drops for a cycle before the next write.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mbgac_pkg::CFG_FLOOR: gate_floor_q = val;
      mbgac_pkg::CFG_CEIL: gate_ceiling_q = val;
      mbgac_pkg::CFG_TARGET: peak_target_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Draws a sample: mostly quiet noise that sits around the gate, some
  // speech-like levels, and now and then the full-scale extremes.
  function automatic logic signed [15:0] draw_sample(int dc_bias);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return 16'(dc_bias + $signed($urandom_range(0, 800)) - 400);
    if (kind < 8) return 16'(dc_bias + $signed($urandom_range(0, 24000)) - 12000);
    if (kind == 8) return 16'($urandom);
    return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
  endfunction

  // A run of random blocks. Lengths favour short blocks; a block of the full
  // depth sometimes comes without an end mark to close on a full store.
  task automatic random_blocks(input int items);
    int sent, len, dc_bias;
    logic last;
    cleaned_t none;
    none = '{default: '0};
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 5))
        0: len = DEPTH;
        1: len = $urandom_range(1, 3);
        default: len = $urandom_range(2, 24);
      endcase
      if (len > items - sent) len = items - sent;
      dc_bias = $signed($urandom_range(0, 4000)) - 2000;
      for (int i = 0; i < len; i++) begin
        last = (i == len - 1);
        if (last && len == DEPTH) last = ($urandom_range(0, 1) != 0);
        send_sample(draw_sample(dc_bias), last, 1'b0, none);
      end
      sent += len;
    end
  endtask

  // Directed table: single-sample blocks always clean to silence, so their
  // results can be typed in; the rest cover extremes and the gate region.
  row_t directed[] = '{
    '{16'sd0, 1, 1, 16'sd0, 1, 16'd0, 16'd0},
    '{16'sh7fff, 1, 1, 16'sd0, 1, 16'd0, 16'd0},
    '{16'sh8000, 1, 1, 16'sd0, 1, 16'd0, 16'd0},
    '{16'sh7fff, 0, 0, 0, 0, 0, 0},
    '{16'sh8000, 0, 0, 0, 0, 0, 0},
    '{16'sd0, 0, 0, 0, 0, 0, 0},
    '{16'sd1, 1, 0, 0, 0, 0, 0},
    '{16'sd10, 0, 0, 0, 0, 0, 0},
    '{-16'sd10, 0, 0, 0, 0, 0, 0},
    '{16'sd50, 0, 0, 0, 0, 0, 0},
    '{-16'sd50, 0, 0, 0, 0, 0, 0},
    '{16'sd100, 0, 0, 0, 0, 0, 0},
    '{-16'sd100, 0, 0, 0, 0, 0, 0},
    '{16'sd400, 0, 0, 0, 0, 0, 0},
    '{-16'sd400, 1, 0, 0, 0, 0, 0},
    '{16'sd1000, 0, 0, 0, 0, 0, 0},
    '{-16'sd20000, 0, 0, 0, 0, 0, 0},
    '{16'sd30000, 0, 0, 0, 0, 0, 0},
    '{16'sd5, 0, 0, 0, 0, 0, 0},
    '{-16'sd5, 1, 0, 0, 0, 0, 0},
    '{-16'sd1, 0, 0, 0, 0, 0, 0},
    '{16'sd1, 1, 0, 0, 0, 0, 0}
  };

  // Result checker: the receiver never stalls, so every strobe is compared
  // at once with the oldest expectation.
  always @(posedge clk) begin
    cleaned_t want;
    if (rst_n && out_valid) begin
      if (cleaned_q.size() == 0) begin
        $display("%0t: unexpected result sample=%0d run_end=%0d", $time,
                 out_sample_out, out_run_end);
        errors++;
      end else begin
        want = cleaned_q.pop_front();
        if (out_sample_out !== want.smp) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, want.smp,
                   out_sample_out);
          errors++;
        end
        if (out_run_end !== want.run_end) begin
          $display("%0t: run_end expected %0d actual %0d", $time, want.run_end,
                   out_run_end);
          errors++;
        end
        if (out_level_mean_abs !== want.mean_abs) begin
          $display("%0t: level_mean_abs expected %0d actual %0d", $time,
                   want.mean_abs, out_level_mean_abs);
          errors++;
        end
        if (out_level_peak !== want.peak) begin
          $display("%0t: level_peak expected %0d actual %0d", $time, want.peak,
                   out_level_peak);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request, result or register write
  // is accepted. The settle pauses are far shorter than the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cleaned_t typed_res;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset settings.
    foreach (directed[i]) begin
      typed_res = '{directed[i].e_smp, directed[i].e_end, directed[i].e_mean,
                    directed[i].e_peak};
      send_sample(directed[i].smp, directed[i].last, directed[i].typed, typed_res);
    end
    drain_results();
    random_blocks(50);
    drain_results();

    // Widest gate range with the largest target.
    write_reg(mbgac_pkg::CFG_FLOOR, 15'd0);
    write_reg(mbgac_pkg::CFG_CEIL, 15'd32767);
    write_reg(mbgac_pkg::CFG_TARGET, 15'd32767);
    random_blocks(55);
    drain_results();

    // Floor above ceiling: the floor wins. Smallest nonzero target.
    write_reg(mbgac_pkg::CFG_FLOOR, 15'd32767);
    write_reg(mbgac_pkg::CFG_CEIL, 15'd0);
    write_reg(mbgac_pkg::CFG_TARGET, 15'd1);
    random_blocks(50);
    drain_results();

    // A zero target drives the gain to its lower limit in every block with a nonzero pass-2 peak.
    write_reg(mbgac_pkg::CFG_FLOOR, 15'd40);
    write_reg(mbgac_pkg::CFG_CEIL, 15'd280);
    write_reg(mbgac_pkg::CFG_TARGET, 15'd0);
    random_blocks(45);
    drain_results();

    // A random setting to finish on.
    write_reg(mbgac_pkg::CFG_FLOOR, 15'($urandom_range(0, 600)));
    write_reg(mbgac_pkg::CFG_CEIL, 15'($urandom_range(0, 32767)));
    write_reg(mbgac_pkg::CFG_TARGET, 15'($urandom_range(1, 32767)));
    random_blocks(55);
    drain_results();

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
